/* hdl/sust_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted unique slot table package
// Shared field widths, operation and status codes, and the cell command type.
// ----------------------------------------------------------------------------
package sust_pkg;

    localparam int SLOT_W   = 16;
    localparam int LIMIT_W  = 17;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 3;
    localparam int POS_W    = 5;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MERGED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd5;
    localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd6;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'h10000;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              flag;
        logic              shift;
        logic              merge;
    } cell_cmd_t;

endpackage
`default_nettype wire

/* hdl/sorted_unique_slot_table_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted unique slot table core
// Ascending table of distinct slots with anchor flags, held in a row of cells.
// ----------------------------------------------------------------------------
// An accepted item waits in the input register until the result register is
// free; it then executes, and its result is registered. A new item is taken
// only after the row of cells has been updated and the result is registered.
// Reset clears the entry count, the busy and result flags, and sets the slot
// limit to 65536. Entry contents are not reset.
module sorted_unique_slot_table_core #(
    parameter int MAX_ENTRIES = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [sust_pkg::LIMIT_W-1:0]   cfg_wdata,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [sust_pkg::KIND_W-1:0]    kind,
    input  wire logic [sust_pkg::SLOT_W-1:0]    slot,
    input  wire logic                           anchor_flag,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [sust_pkg::STATUS_W-1:0]       status,
    output logic [sust_pkg::POS_W-1:0]          position,
    output logic                                entry_anchor,
    output logic [sust_pkg::POS_W-1:0]          entry_count
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);

    logic [sust_pkg::LIMIT_W-1:0]  limit_reg;
    logic                          busy_reg;
    logic [sust_pkg::KIND_W-1:0]   kind_reg;
    logic [sust_pkg::SLOT_W-1:0]   slot_reg;
    logic                          flag_reg;
    logic [CW-1:0]                 count_reg;
    logic [CW-1:0]                 count_next;
    logic                          out_valid_reg;
    logic [sust_pkg::STATUS_W-1:0] status_reg;
    logic [sust_pkg::STATUS_W-1:0] status_next;
    logic [CW-1:0]                 pos_reg;
    logic [CW-1:0]                 pos_next;
    logic                          anchor_reg;
    logic                          anchor_next;

    logic                          exec;
    logic                          in_range;
    logic                          dup;
    logic                          full;
    logic                          found_anchor;
    logic [CW-1:0]                 boundary;
    logic [MAX_ENTRIES-1:0]        lt_vec;
    logic [MAX_ENTRIES-1:0]        eq_vec;
    logic [MAX_ENTRIES-1:0]        cell_valid;
    logic [MAX_ENTRIES-1:0]        anc_vec;
    logic [sust_pkg::SLOT_W-1:0]   slot_vec [MAX_ENTRIES];
    sust_pkg::cell_cmd_t           cmd;
    logic [CW+sust_pkg::POS_W-1:0] pos_wide;
    logic [CW+sust_pkg::POS_W-1:0] cnt_wide;

    assign exec     = busy_reg && (!out_valid_reg || out_ready);
    assign in_ready = !busy_reg;
    assign in_range = {1'b0, slot_reg} < limit_reg;
    assign dup      = |eq_vec;
    assign full     = count_reg >= CW'(MAX_ENTRIES);
    assign found_anchor = |(eq_vec & anc_vec);

    always_comb
    begin
        boundary = CW'(MAX_ENTRIES);
        for (int i = MAX_ENTRIES - 1; i >= 0; i--)
        begin
            if (!lt_vec[i])
            begin
                boundary = CW'(i);
            end
        end
    end

    always_comb
    begin
        cmd.slot  = slot_reg;
        cmd.flag  = flag_reg;
        cmd.shift = 1'b0;
        cmd.merge = 1'b0;
        count_next  = count_reg;
        status_next = sust_pkg::ST_NOTFOUND;
        pos_next    = '0;
        anchor_next = 1'b0;
        case (kind_reg)
            sust_pkg::KIND_INSERT:
            begin
                if (!in_range)
                begin
                    status_next = sust_pkg::ST_RANGE;
                end
                else if (dup)
                begin
                    cmd.merge   = exec;
                    status_next = sust_pkg::ST_MERGED;
                    pos_next    = boundary;
                    anchor_next = found_anchor | flag_reg;
                end
                else if (full)
                begin
                    status_next = sust_pkg::ST_FULL;
                end
                else
                begin
                    cmd.shift   = exec;
                    count_next  = count_reg + CW'(1);
                    status_next = sust_pkg::ST_INSERTED;
                    pos_next    = boundary;
                    anchor_next = flag_reg;
                end
            end
            sust_pkg::KIND_LOOKUP:
            begin
                if (dup)
                begin
                    status_next = sust_pkg::ST_FOUND;
                    pos_next    = boundary;
                    anchor_next = found_anchor;
                end
            end
            sust_pkg::KIND_CLEAR:
            begin
                count_next  = '0;
                status_next = sust_pkg::ST_CLEARED;
            end
            default:
            begin
                status_next = sust_pkg::ST_NOTFOUND;
            end
        endcase
    end

    for (genvar g = 0; g < MAX_ENTRIES; g++)
    begin : g_cell
        logic                        left_lt;
        logic [sust_pkg::SLOT_W-1:0] left_slot;
        logic                        left_anchor;

        assign cell_valid[g] = CW'(g) < count_reg;

        if (g == 0)
        begin : g_first
            assign left_lt     = 1'b1;
            assign left_slot   = slot_reg;
            assign left_anchor = flag_reg;
        end
        else
        begin : g_rest
            assign left_lt     = lt_vec[g-1];
            assign left_slot   = slot_vec[g-1];
            assign left_anchor = anc_vec[g-1];
        end

        sust_cell u_cell (
            .clk         (clk),
            .cmd         (cmd),
            .valid       (cell_valid[g]),
            .left_lt     (left_lt),
            .left_slot   (left_slot),
            .left_anchor (left_anchor),
            .lt          (lt_vec[g]),
            .eq          (eq_vec[g]),
            .slot_q      (slot_vec[g]),
            .anchor_q    (anc_vec[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= sust_pkg::LIMIT_RESET;
            busy_reg      <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            if (in_valid && in_ready)
            begin
                busy_reg <= 1'b1;
            end
            else if (exec)
            begin
                busy_reg <= 1'b0;
            end
            if (exec)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            kind_reg <= kind;
            slot_reg <= slot;
            flag_reg <= anchor_flag;
        end
        if (exec)
        begin
            status_reg <= status_next;
            pos_reg    <= pos_next;
            anchor_reg <= anchor_next;
        end
    end

    assign pos_wide = {{sust_pkg::POS_W{1'b0}}, pos_reg};
    assign cnt_wide = {{sust_pkg::POS_W{1'b0}}, count_reg};

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign position     = pos_wide[sust_pkg::POS_W-1:0];
    assign entry_anchor = anchor_reg;
    assign entry_count  = cnt_wide[sust_pkg::POS_W-1:0];

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_ENTRIES))
        else $error("entry count exceeds table depth");

    a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (((lt_vec >> 1) & ~lt_vec) == '0))
        else $error("table entries are not in ascending order");

    a_unique: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> $onehot0(eq_vec))
        else $error("slot present in more than one entry");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && out_valid_reg && !out_ready) |=> busy_reg)
        else $error("item dropped while result stalled");

    a_result_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        exec |=> out_valid_reg)
        else $error("executed item produced no result");

endmodule
`default_nettype wire

/* hdl/sust_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted unique slot table cell
// Holds one entry, compares it with the current slot, and on an insert keeps
// it, takes the new slot or its left neighbor's, or ORs the flag on a match.
// ----------------------------------------------------------------------------
module sust_cell (
    input  wire logic                      clk,
    input  wire sust_pkg::cell_cmd_t       cmd,
    input  wire logic                      valid,
    input  wire logic                      left_lt,
    input  wire logic [sust_pkg::SLOT_W-1:0] left_slot,
    input  wire logic                      left_anchor,
    output logic                           lt,
    output logic                           eq,
    output logic [sust_pkg::SLOT_W-1:0]    slot_q,
    output logic                           anchor_q
);

    logic [sust_pkg::SLOT_W-1:0] slot_reg;
    logic [sust_pkg::SLOT_W-1:0] slot_next;
    logic                        anchor_reg;
    logic                        anchor_next;

    assign lt       = valid && (slot_reg < cmd.slot);
    assign eq       = valid && (slot_reg == cmd.slot);
    assign slot_q   = slot_reg;
    assign anchor_q = anchor_reg;

    always_comb
    begin
        slot_next   = slot_reg;
        anchor_next = anchor_reg;
        if (cmd.shift && !lt)
        begin
            if (left_lt)
            begin
                slot_next   = cmd.slot;
                anchor_next = cmd.flag;
            end
            else
            begin
                slot_next   = left_slot;
                anchor_next = left_anchor;
            end
        end
        else if (cmd.merge && eq)
        begin
            anchor_next = anchor_reg | cmd.flag;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg   <= slot_next;
        anchor_reg <= anchor_next;
    end

endmodule
`default_nettype wire
